// ===== rtl/core/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the threshold crossing width core
// no dependencies; compiled first

package tcw_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// register indexes
	localparam cfg_idx_t CFG_THRESHOLD  = 1'd0;
	localparam cfg_idx_t CFG_DEPTH_MODE = 1'd1;

	localparam cfg_data_t THRESHOLD_RESET = 16'd32768;

	// crossing counter
	typedef logic [1:0] count_t;

	localparam count_t COUNT_MAX    = 2'd3;
	localparam count_t EDGES_NEEDED = 2'd2;

endpackage

// ===== rtl/core/tcw_if.sv =====
// tcw_if: valid/ready channels of the threshold crossing width core
// tcw_in_if carries one profile sample, tcw_out_if one width result

interface tcw_in_if #(
	parameter int POSITION_BITS = 32,
	parameter int DOSE_BITS     = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [POSITION_BITS-1:0] sample_position;
	logic        [DOSE_BITS-1:0]     sample_dose;
	logic                            is_last;

	modport source (output valid, sample_position, sample_dose, is_last, input ready);
	modport sink   (input valid, sample_position, sample_dose, is_last, output ready);
endinterface

interface tcw_out_if #(
	parameter int POSITION_BITS = 32
);
	logic                            valid;
	logic                            ready;
	logic                            width_valid;
	logic signed [POSITION_BITS-1:0] first_edge;
	logic signed [POSITION_BITS-1:0] second_edge;
	logic        [1:0]               crossings_seen;

	modport source (output valid, width_valid, first_edge, second_edge, crossings_seen,
		input ready);
	modport sink   (input valid, width_valid, first_edge, second_edge, crossings_seen,
		output ready);
endinterface

// ===== rtl/core/threshold_crossing_width_core.sv =====
// threshold_crossing_width_core: width of a profile at a threshold dose level
// uses tcw_pkg, tcw_in_if, tcw_out_if and the serial unit tcw_interp
//
// Usage
//   sample channel: one profile sample per item (position, dose, is_last).
//   result channel: one item per profile, sent after the sample with is_last.
//   config port: cfg_we/cfg_idx/cfg_wdata, threshold_level and
//   depth_profile_mode; write only while no profile sample is in flight.
// Timing
//   one sample at a time. A sample with no crossing passes from accept
//   through the evaluate state back to ready. A crossing runs the bit-serial
//   interpolation unit: DOSE_BITS multiply steps plus POSITION_BITS divide steps.
//   The result register loads in the emit state, which follows the last sample's
//   evaluation or interpolation, once the register is free.
// Reset
//   threshold 32768, depth mode off, profile state and result valid flag clear.
// Stall
//   the result register holds its item until taken; samples keep flowing and
//   only the next last sample waits for the register to empty.

module threshold_crossing_width_core #(
	parameter int POSITION_BITS = 32,
	parameter int DOSE_BITS     = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	tcw_in_if.sink             sample,
	tcw_out_if.source          result,
	input  logic               cfg_we,
	input  tcw_pkg::cfg_idx_t  cfg_idx,
	input  tcw_pkg::cfg_data_t cfg_wdata
);
	import tcw_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;

	// configuration
	cfg_data_t thr_q;
	logic      depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESHOLD_RESET;
			depth_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_THRESHOLD:  thr_q   <= cfg_wdata;
				CFG_DEPTH_MODE: depth_q <= cfg_wdata[0];
				default:        thr_q   <= thr_q;
			endcase
		end
	end

	// threshold at dose width
	logic [DOSE_BITS+CFG_DATA_W-1:0] thr_ext;
	logic [DOSE_BITS-1:0]            thr;

	assign thr_ext = {{DOSE_BITS{1'b0}}, thr_q};
	assign thr     = thr_ext[DOSE_BITS-1:0];

	// captured sample
	logic signed [POSITION_BITS-1:0] x2_q;
	logic        [DOSE_BITS-1:0]     d2_q;
	logic                            last_q;

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			x2_q   <= sample.sample_position;
			d2_q   <= sample.sample_dose;
			last_q <= sample.is_last;
		end
	end

	// profile state
	logic signed [POSITION_BITS-1:0] prev_pos_q;
	logic        [DOSE_BITS-1:0]     prev_dose_q;
	logic                            have_prev_q;
	count_t                          count_q;
	logic        [POSITION_BITS-1:0] edge1_q;
	logic        [POSITION_BITS-1:0] edge2_q;

	// crossing detection and interpolation operands
	logic                     cur_hi;
	logic                     prev_hi;
	logic                     rise;
	logic                     fall;
	logic                     step_neg;
	logic [POSITION_BITS-1:0] step_mag;
	logic [DOSE_BITS-1:0]     op_mul;
	logic [DOSE_BITS-1:0]     op_dvs;
	logic                     op_sub;
	logic [POSITION_BITS-1:0] op_base;
	logic                     unit_start;
	logic                     unit_done;
	logic [POSITION_BITS-1:0] unit_res;

	assign cur_hi   = d2_q >= thr;
	assign prev_hi  = prev_dose_q >= thr;
	assign rise     = have_prev_q && cur_hi && !prev_hi;
	assign fall     = have_prev_q && !cur_hi && prev_hi;
	assign step_neg = x2_q < prev_pos_q;
	assign step_mag = step_neg ? POSITION_BITS'(prev_pos_q - x2_q)
		: POSITION_BITS'(x2_q - prev_pos_q);
	assign op_mul   = rise ? thr - prev_dose_q : thr - d2_q;
	assign op_dvs   = rise ? d2_q - prev_dose_q : prev_dose_q - d2_q;
	assign op_sub   = rise ? step_neg : !step_neg;
	assign op_base  = rise ? prev_pos_q : x2_q;

	assign unit_start = (state_q == ST_EVAL) && (rise || fall);

	tcw_interp #(
		.POS_BITS  (POSITION_BITS),
		.DOSE_BITS (DOSE_BITS)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.mag    (step_mag),
		.mul    (op_mul),
		.dvs    (op_dvs),
		.sub    (op_sub),
		.base   (op_base),
		.done   (unit_done),
		.res    (unit_res)
	);

	// result register
	logic                     res_valid_q;
	logic                     res_width_valid_q;
	logic [POSITION_BITS-1:0] res_first_q;
	logic [POSITION_BITS-1:0] res_second_q;
	count_t                   res_count_q;
	logic                     res_free;
	logic                     width_ok;

	assign res_free = !res_valid_q || result.ready;
	assign width_ok = !depth_q && (count_q == EDGES_NEEDED);

	// control and profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_pos_q  <= '0;
			prev_dose_q <= '0;
			have_prev_q <= 1'b0;
			count_q     <= '0;
			edge1_q     <= '0;
			edge2_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result flag: set on emit, cleared when taken
			if (state_q == ST_EMIT && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					prev_pos_q  <= x2_q;
					prev_dose_q <= d2_q;
					have_prev_q <= 1'b1;
					if (rise || fall) begin
						state_q <= ST_CALC;
					end else if (last_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CALC: begin
					if (unit_done) begin
						if (count_q == 2'd0) begin
							edge1_q <= unit_res;
						end
						if (count_q == 2'd1) begin
							edge2_q <= unit_res;
						end
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						prev_pos_q  <= '0;
						prev_dose_q <= '0;
						have_prev_q <= 1'b0;
						count_q     <= '0;
						edge1_q     <= '0;
						edge2_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && res_free) begin
			res_width_valid_q <= width_ok;
			res_first_q       <= width_ok ? edge1_q : '0;
			res_second_q      <= width_ok ? edge2_q : '0;
			res_count_q       <= depth_q ? 2'd0 : count_q;
		end
	end

	assign sample.ready          = (state_q == ST_IDLE);
	assign result.valid          = res_valid_q;
	assign result.width_valid    = res_width_valid_q;
	assign result.first_edge     = res_first_q;
	assign result.second_edge    = res_second_q;
	assign result.crossings_seen = res_count_q;

endmodule

// ===== rtl/core/tcw_interp.sv =====
// tcw_interp: bit-serial interpolation unit, res = base -/+ floor(mag * mul / dvs)
// shift-add multiply, then restoring divide, both one bit per cycle; uses tcw_pkg

module tcw_interp #(
	parameter int POS_BITS  = 32,
	parameter int DOSE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [POS_BITS-1:0] mag,
	input  logic [DOSE_BITS-1:0] mul,
	input  logic [DOSE_BITS-1:0] dvs,
	input  logic                sub,
	input  logic [POS_BITS-1:0] base,
	output logic                done,
	output logic [POS_BITS-1:0] res
);
	import tcw_pkg::*;

	localparam int PW        = POS_BITS + DOSE_BITS;
	localparam int STEPS_MAX = (POS_BITS > DOSE_BITS) ? POS_BITS : DOSE_BITS;
	localparam int CNT_W     = $clog2(STEPS_MAX);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;
	localparam logic [1:0] PH_FIN  = 2'd3;

	logic [1:0]           phase_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PW-1:0]        prod_q;
	logic [POS_BITS-1:0]  mag_q;
	logic [DOSE_BITS-1:0] dvs_q;
	logic                 sub_q;
	logic [POS_BITS-1:0]  base_q;
	logic [POS_BITS-1:0]  res_q;
	logic                 done_q;

	// multiply step: add mag when the low multiplier bit is set, shift right
	logic [POS_BITS-1:0]  mul_addend;
	logic [POS_BITS:0]    mul_sum;
	logic [PW-1:0]        mul_next;

	assign mul_addend = prod_q[0] ? mag_q : '0;
	assign mul_sum    = {1'b0, prod_q[PW-1:DOSE_BITS]} + {1'b0, mul_addend};
	assign mul_next   = {mul_sum, prod_q[DOSE_BITS-1:1]};

	// divide step: remainder in the top bits, quotient shifts in at the bottom
	logic [DOSE_BITS:0]   div_trial;
	logic [DOSE_BITS:0]   div_diff;
	logic                 div_ge;
	logic [DOSE_BITS-1:0] div_rem;
	logic [PW-1:0]        div_next;

	assign div_trial = {prod_q[PW-1:POS_BITS], prod_q[POS_BITS-1]};
	assign div_diff  = div_trial - {1'b0, dvs_q};
	assign div_ge    = ~div_diff[DOSE_BITS];
	assign div_rem   = div_ge ? div_diff[DOSE_BITS-1:0] : div_trial[DOSE_BITS-1:0];
	assign div_next  = {div_rem, prod_q[POS_BITS-2:0], div_ge};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					if (cnt_q == CNT_W'(DOSE_BITS - 1)) begin
						phase_q <= PH_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DIV: begin
					if (cnt_q == CNT_W'(POS_BITS - 1)) begin
						phase_q <= PH_FIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_FIN: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					prod_q <= {{POS_BITS{1'b0}}, mul};
					mag_q  <= mag;
					dvs_q  <= dvs;
					sub_q  <= sub;
					base_q <= base;
				end
			end
			PH_MUL: begin
				prod_q <= mul_next;
			end
			PH_DIV: begin
				prod_q <= div_next;
			end
			PH_FIN: begin
				res_q <= sub_q ? base_q - prod_q[POS_BITS-1:0]
					: base_q + prod_q[POS_BITS-1:0];
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/core/tcw_checker.sv =====
// tcw_checker: port-level checks of threshold_crossing_width_core
// uses tcw_pkg; bound to threshold_crossing_width_core at the end of this file

module tcw_checker #(
	parameter int POSITION_BITS = 32
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_valid,
	input logic                     s_ready,
	input logic                     r_valid,
	input logic                     r_ready,
	input logic                     r_width_valid,
	input logic [POSITION_BITS-1:0] r_first_edge,
	input logic [POSITION_BITS-1:0] r_second_edge,
	input logic [1:0]               r_crossings_seen
);
	import tcw_pkg::*;

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result item dropped while stalled");

	// a stalled result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_width_valid) && $stable(r_first_edge)
			&& $stable(r_second_edge) && $stable(r_crossings_seen))
		else $error("result payload changed while stalled");

	// one sample at a time
	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample taken while one is in flight");

	// a valid width needs exactly two crossings
	a_width_count: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_width_valid |-> r_crossings_seen == EDGES_NEEDED)
		else $error("valid width without two crossings");

	// an invalid width reports zero edges
	a_zero_edges: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_width_valid |-> r_first_edge == '0 && r_second_edge == '0)
		else $error("invalid width with nonzero edges");

endmodule

bind threshold_crossing_width_core tcw_checker #(
	.POSITION_BITS (POSITION_BITS)
) u_tcw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.s_valid          (sample.valid),
	.s_ready          (sample.ready),
	.r_valid          (result.valid),
	.r_ready          (result.ready),
	.r_width_valid    (result.width_valid),
	.r_first_edge     (result.first_edge),
	.r_second_edge    (result.second_edge),
	.r_crossings_seen (result.crossings_seen)
);
